>>> src/msort_pkg.sv
// Shared types for the merge sorter: input and result words.
// No dependencies; imported by the top level and its checker.
package msort_pkg;

	// One input word: a value of the set and the end-of-set mark
	typedef struct packed {
		logic signed [31:0] sort_value;
		logic               is_last;
	} item_word_t;

	// One result word: a sorted value with its end and overflow marks
	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               last_out;
		logic               overflow;
	} result_word_t;

endpackage

>>> src/merge_sorter_unit.sv
// Operation: loading takes one word per accepted handshake, storing it while there is room; the
// sort runs ceil(log2 n) passes, each a setup read and then one merge write per cycle; emission
// reads each word, then loads it into the output register once that register is free. Only one
// set is handled at a time: no new word is taken until the last result word has been loaded.
// Reset: arst_n clears the state machine, count, overflow flag and output valid at once;
// the two value memories are not cleared and hold nothing meaningful until loaded.
module merge_sorter_unit
	import msort_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  item_word_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output result_word_t result
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int PW = CW + 1;
	localparam int SW = CW + 2;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

	localparam logic [2:0] ST_LOAD    = 3'd0;
	localparam logic [2:0] ST_SETUP   = 3'd1;
	localparam logic [2:0] ST_MERGE   = 3'd2;
	localparam logic [2:0] ST_EMIT_RD = 3'd3;
	localparam logic [2:0] ST_EMIT_LD = 3'd4;

	// Ping-pong value memories
	logic [31:0] mem0 [MAX_ITEMS];
	logic [31:0] mem1 [MAX_ITEMS];
	logic [31:0] rd0_a_q, rd0_b_q, rd1_a_q, rd1_b_q;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic          drop_q;
	logic          sel_q;
	logic [PW-1:0] width_q;
	logic [CW-1:0] a_q, b_q, mid_q, hi_q, k_q, e_q;
	logic          res_valid_q;
	result_word_t  res_q;

	logic               accept;
	logic               has_room;
	logic [CW-1:0]      cnt_new;
	logic signed [31:0] ra, rb, wr_data;
	logic               take_a;
	logic [CW-1:0]      k_inc, a_n, b_n;
	logic               run_end, pass_end;
	logic [SW-1:0]      n_x, w_x, w2_x, hi_x, sum1, sum2;
	logic [CW-1:0]      st_mid, st_hi, nr_mid, nr_hi;
	logic [PW-1:0]      width_dbl;
	logic [CW-1:0]      addr_a, addr_b;
	logic               emit_last, emit_load;
	logic               wr0_en, wr1_en;
	logic [AW-1:0]      wr0_addr;
	logic [31:0]        wr0_data;

	assign item_ready = (state_q == ST_LOAD);
	assign accept     = item_valid && item_ready;
	assign has_room   = (count_q < MAX_CNT);
	assign cnt_new    = count_q + CW'(has_room);

	// Select the source memory's read data
	assign ra = sel_q ? rd1_a_q : rd0_a_q;
	assign rb = sel_q ? rd1_b_q : rd0_b_q;

	// Merge decision: left run wins ties, exhausted run never wins
	assign take_a  = (a_q != mid_q) && ((b_q == hi_q) || (ra <= rb));
	assign wr_data = take_a ? ra : rb;
	assign k_inc   = k_q + 1'b1;
	assign a_n     = a_q + CW'(take_a);
	assign b_n     = b_q + CW'(!take_a);
	assign run_end  = (k_inc == hi_q);
	assign pass_end = run_end && (hi_q == count_q);

	// Run bounds, clamped to the set size
	assign n_x    = SW'(count_q);
	assign w_x    = SW'(width_q);
	assign w2_x   = w_x << 1;
	assign hi_x   = SW'(hi_q);
	assign sum1   = hi_x + w_x;
	assign sum2   = hi_x + w2_x;
	assign st_mid = (w_x < n_x) ? CW'(w_x) : count_q;
	assign st_hi  = (w2_x < n_x) ? CW'(w2_x) : count_q;
	assign nr_mid = (sum1 < n_x) ? CW'(sum1) : count_q;
	assign nr_hi  = (sum2 < n_x) ? CW'(sum2) : count_q;
	assign width_dbl = width_q << 1;

	// Emission control
	assign emit_last = (CW'(e_q + 1'b1) == count_q);
	assign emit_load = (state_q == ST_EMIT_LD) && (!res_valid_q || result_ready);

	// Read addresses: aim at the next heads so the data lands as they are needed
	always_comb begin
		addr_a = '0;
		addr_b = '0;
		case (state_q)
			ST_SETUP: begin
				addr_a = '0;
				addr_b = st_mid;
			end
			ST_MERGE: begin
				if (run_end) begin
					addr_a = hi_q;
					addr_b = nr_mid;
				end else begin
					addr_a = a_n;
					addr_b = b_n;
				end
			end
			ST_EMIT_RD, ST_EMIT_LD: begin
				addr_a = e_q;
				addr_b = e_q;
			end
			default: begin
				addr_a = '0;
				addr_b = '0;
			end
		endcase
	end

	// Write ports: loading fills mem0, merging writes the destination memory
	assign wr0_en   = (accept && has_room) || ((state_q == ST_MERGE) && sel_q);
	assign wr0_addr = (state_q == ST_MERGE) ? k_q[AW-1:0] : count_q[AW-1:0];
	assign wr0_data = (state_q == ST_MERGE) ? wr_data : item.sort_value;
	assign wr1_en   = (state_q == ST_MERGE) && !sel_q;

	always_ff @(posedge clk) begin
		if (wr0_en) begin
			mem0[wr0_addr] <= wr0_data;
		end
		rd0_a_q <= mem0[addr_a[AW-1:0]];
		rd0_b_q <= mem0[addr_b[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr1_en) begin
			mem1[k_q[AW-1:0]] <= wr_data;
		end
		rd1_a_q <= mem1[addr_a[AW-1:0]];
		rd1_b_q <= mem1[addr_b[AW-1:0]];
	end

	// Sequencer: load, merge passes, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			drop_q  <= 1'b0;
			sel_q   <= 1'b0;
			width_q <= '0;
			a_q     <= '0;
			b_q     <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			k_q     <= '0;
			e_q     <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						count_q <= cnt_new;
						if (!has_room) begin
							drop_q <= 1'b1;
						end
						if (item.is_last) begin
							sel_q   <= 1'b0;
							width_q <= PW'(1);
							e_q     <= '0;
							state_q <= (cnt_new > CW'(1)) ? ST_SETUP : ST_EMIT_RD;
						end
					end
				end
				ST_SETUP: begin
					a_q     <= '0;
					k_q     <= '0;
					mid_q   <= st_mid;
					b_q     <= st_mid;
					hi_q    <= st_hi;
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (pass_end) begin
						sel_q   <= ~sel_q;
						width_q <= width_dbl;
						e_q     <= '0;
						state_q <= (SW'(width_dbl) < n_x) ? ST_SETUP : ST_EMIT_RD;
					end else if (run_end) begin
						a_q   <= hi_q;
						k_q   <= hi_q;
						mid_q <= nr_mid;
						b_q   <= nr_mid;
						hi_q  <= nr_hi;
					end else begin
						a_q <= a_n;
						b_q <= b_n;
						k_q <= k_inc;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (emit_load) begin
						if (emit_last) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							e_q     <= e_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			res_q.sorted_value <= ra;
			res_q.last_out     <= emit_last;
			res_q.overflow     <= drop_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

>>> src/msort_checker.sv
// Port-level checks for merge_sorter_unit, attached by the bind below.
// Depends on msort_pkg for the word types.
module msort_checker
	import msort_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         item_valid,
	input logic         item_ready,
	input item_word_t   item,
	input logic         result_valid,
	input logic         result_ready,
	input result_word_t result
);

	// A stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed or dropped while stalled");

	// No new word is taken while a set is still being emitted
	a_no_load_mid_set: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_out |-> !item_ready)
		else $error("input accepted while a set is still being emitted");

	// The closing word of a set stops the input side
	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.is_last |=> !item_ready)
		else $error("input still ready after the closing word");

endmodule

bind merge_sorter_unit msort_checker u_msort_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

>>> sim/tb_merge_sorter_unit.sv
// Self-checking testbench for merge_sorter_unit: feeds sets of signed words and checks each
// sorted result word against an in-bench model of the stable sort with overflow marking.
// Depends on msort_pkg (word types) and the merge_sorter_unit RTL.
module tb_merge_sorter_unit
	import msort_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SET_CAP    = 64;
	localparam int SHOW_LIMIT = 10;

	// Model of the sorter: collects a set, sorts it on the closing word, queues result words
	class sort_checker;
		int                 cap;
		logic signed [31:0] held_values[$];
		bit                 dropped;
		result_word_t       expected_words[$];
		int                 mismatches;
		int                 checked;

		function new(int set_cap);
			cap        = set_cap;
			dropped    = 0;
			mismatches = 0;
			checked    = 0;
		endfunction

		// Note one accepted input word; on the closing word, predict the whole sorted set
		function void take_item(item_word_t w);
			logic signed [31:0] vals[];
			logic signed [31:0] key;
			result_word_t       r;
			int                 n;
			int                 j;
			if (held_values.size() < cap)
				held_values.push_back(w.sort_value);
			else
				dropped = 1;
			if (!w.is_last)
				return;
			n = held_values.size();
			vals = new[n];
			foreach (held_values[i])
				vals[i] = held_values[i];
			// stable insertion sort: equal values keep arrival order
			for (int i = 1; i < n; i++) begin
				key = vals[i];
				j = i - 1;
				while (j >= 0 && vals[j] > key) begin
					vals[j + 1] = vals[j];
					j--;
				end
				vals[j + 1] = key;
			end
			for (int i = 0; i < n; i++) begin
				r.sorted_value = vals[i];
				r.last_out     = (i == n - 1);
				r.overflow     = dropped;
				expected_words.push_back(r);
			end
			held_values.delete();
			dropped = 0;
		endfunction

		// Compare one accepted result word with the oldest prediction
		function void check_result(result_word_t got);
			result_word_t exp_w;
			checked++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("result word %0d: none expected, got value %0d last %0b ovf %0b",
						checked, got.sorted_value, got.last_out, got.overflow);
				return;
			end
			exp_w = expected_words.pop_front();
			if (got.sorted_value !== exp_w.sorted_value || got.last_out !== exp_w.last_out ||
					got.overflow !== exp_w.overflow) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display({"result word %0d: expected value %0d last %0b ovf %0b,",
						" got value %0d last %0b ovf %0b"},
						checked, exp_w.sorted_value, exp_w.last_out, exp_w.overflow,
						got.sorted_value, got.last_out, got.overflow);
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         item_valid;
	logic         item_ready;
	item_word_t   item;
	logic         result_valid;
	logic         result_ready;
	result_word_t result;

	int           tx_idle_pct;
	int           rx_idle_pct;
	sort_checker  sorted_model;

	merge_sorter_unit #(
		.MAX_ITEMS(SET_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #5 clk = ~clk;

	// Check each accepted result word, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sorted_model.check_result(result);
		result_ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	// Offer one word, idling first at random; keep valid high into the next word
	task automatic send_word(item_word_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			item       <= {$urandom, 1'($urandom)};
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do
			@(posedge clk);
		while (!item_ready);
		sorted_model.take_item(w);
	endtask

	task automatic send_value(logic signed [31:0] v, logic last);
		item_word_t w;
		w.sort_value = v;
		w.is_last    = last;
		send_word(w);
	endtask

	// Mix extremes, a narrow band for duplicates, and full-range values
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(3))
			0: return $signed($urandom_range(8)) - 4;
			1: begin
				case ($urandom_range(3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh0000_0000;
					default: return -32'sd1;
				endcase
			end
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic send_set(int len);
		for (int i = 0; i < len; i++)
			send_value(pick_value(), i == len - 1);
	endtask

	// Random sets for one idling phase, with one set sized around capacity after the first few
	task automatic run_phase(int budget, int big_len);
		int  sent;
		int  len;
		bit  big_done;
		sent     = 0;
		big_done = 0;
		while (sent < budget) begin
			if (!big_done && sent >= budget / 4) begin
				len      = big_len;
				big_done = 1;
			end else if ($urandom_range(7) == 0)
				len = $urandom_range(20, 9);
			else
				len = $urandom_range(8, 1);
			send_set(len);
			sent += len;
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_ready = 1'b0;
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		sorted_model = new(SET_CAP);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single-word sets at both extremes
		tx_idle_pct = 21;
		rx_idle_pct = 52;
		send_value(32'sh7fff_ffff, 1'b1);
		send_value(32'sh8000_0000, 1'b1);
		// extremes and neighbors in scrambled order
		send_value(32'sh7fff_ffff, 1'b0);
		send_value(32'sh8000_0000, 1'b0);
		send_value(0, 1'b0);
		send_value(-1, 1'b0);
		send_value(1, 1'b0);
		send_value(32'sh8000_0001, 1'b1);
		// duplicates
		send_value(5, 1'b0);
		send_value(5, 1'b0);
		send_value(-5, 1'b0);
		send_value(-5, 1'b0);
		send_value(5, 1'b1);
		// already ascending, then descending
		send_value(-3, 1'b0);
		send_value(-2, 1'b0);
		send_value(7, 1'b0);
		send_value(9, 1'b1);
		send_value(9, 1'b0);
		send_value(7, 1'b0);
		send_value(-2, 1'b0);
		send_value(-3, 1'b1);

		// random: full set, last word at capacity, words dropped before the last
		run_phase(16, SET_CAP);
		tx_idle_pct = 52;
		rx_idle_pct = 21;
		run_phase(16, SET_CAP + 1);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(16, SET_CAP + $urandom_range(6, 2));
		item_valid <= 1'b0;

		// drain, then watch for stray words
		while (sorted_model.pending() != 0)
			@(posedge clk);
		repeat (4 * SET_CAP) @(posedge clk);
		if (sorted_model.mismatches == 0)
			$display("merge_sorter_unit: match");
		else
			$display("merge_sorter_unit: mismatch");
		$finish;
	end

	// Hard stop far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("merge_sorter_unit: mismatch");
		$finish;
	end

endmodule

>>> files.f
src/msort_pkg.sv
src/merge_sorter_unit.sv
src/msort_checker.sv
sim/tb_merge_sorter_unit.sv
